// ===== sv/fpcam_pkg.sv =====
package fpcam_pkg;

    localparam int POS_WIDTH     = 32;
    localparam int DIR_FRAC_BITS = 14;
    localparam int CORDIC_STEPS  = 16;

    localparam int STEP_IW    = $clog2(CORDIC_STEPS);
    localparam int ANG_W      = 25;
    localparam int PITCH_W    = 24;
    localparam int DIR_W      = 16;
    localparam int SIDE_W     = DIR_W + 1;
    localparam int MUL_W      = 33;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int TRIG_W     = MUL_W;
    localparam int WRAP_W     = 36;
    localparam int WRAP_STEPS = 9;
    localparam int WK_W       = $clog2(WRAP_STEPS);
    localparam int FRONT_SH   = 60 - DIR_FRAC_BITS;
    localparam int TRIG_SH    = 30 - DIR_FRAC_BITS;

    localparam logic signed [WRAP_W-1:0] DEG_89  = 36'sd5832704;
    localparam logic signed [WRAP_W-1:0] DEG_90  = 36'sd5898240;
    localparam logic signed [WRAP_W-1:0] DEG_180 = 36'sd11796480;
    localparam logic signed [WRAP_W-1:0] DEG_360 = 36'sd23592960;
    localparam logic signed [TRIG_W-1:0] CORDIC_K30 = 33'sd652032874;

    localparam logic [3:0] REG_START_X     = 4'd0;
    localparam logic [3:0] REG_START_Y     = 4'd1;
    localparam logic [3:0] REG_START_Z     = 4'd2;
    localparam logic [3:0] REG_START_HEAD  = 4'd3;
    localparam logic [3:0] REG_START_ELEV  = 4'd4;
    localparam logic [3:0] REG_WALK_RATE   = 4'd5;
    localparam logic [3:0] REG_SPRINT_RATE = 4'd6;
    localparam logic [3:0] REG_LOOK_GAIN   = 4'd7;

    localparam logic [2:0] CMD_CURSOR  = 3'd0;
    localparam logic [2:0] CMD_FRAME   = 3'd1;
    localparam logic [2:0] CMD_FORWARD = 3'd2;
    localparam logic [2:0] CMD_BACK    = 3'd3;
    localparam logic [2:0] CMD_RIGHT   = 3'd4;
    localparam logic [2:0] CMD_LEFT    = 3'd5;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CUR_MULX,
        S_CUR_MULY,
        S_CUR_PITCH,
        S_WRAP,
        S_WRAP_FIX,
        S_TRIG_YAW,
        S_WAIT_YAW,
        S_TRIG_PITCH,
        S_WAIT_PITCH,
        S_FRONT_X,
        S_FRONT_Z,
        S_FRONT_END,
        S_FRAME_MUL,
        S_FRAME_END,
        S_MOVE_X,
        S_MOVE_Y,
        S_MOVE_Z,
        S_MOVE_END,
        S_SIDE_TRIG,
        S_SIDE_WAIT,
        S_SIDE_X,
        S_SIDE_Z,
        S_SIDE_END,
        S_OUT
    } state_t;

    function automatic logic signed [ANG_W-1:0] atan_deg(input logic [4:0] idx);
        logic signed [ANG_W-1:0] r;
        case (idx)
            5'd0:    r = 25'sd2949120;
            5'd1:    r = 25'sd1740967;
            5'd2:    r = 25'sd919879;
            5'd3:    r = 25'sd466945;
            5'd4:    r = 25'sd234379;
            5'd5:    r = 25'sd117304;
            5'd6:    r = 25'sd58666;
            5'd7:    r = 25'sd29335;
            5'd8:    r = 25'sd14668;
            5'd9:    r = 25'sd7334;
            5'd10:   r = 25'sd3667;
            5'd11:   r = 25'sd1833;
            5'd12:   r = 25'sd917;
            5'd13:   r = 25'sd458;
            5'd14:   r = 25'sd229;
            5'd15:   r = 25'sd115;
            5'd16:   r = 25'sd57;
            5'd17:   r = 25'sd29;
            5'd18:   r = 25'sd14;
            5'd19:   r = 25'sd7;
            5'd20:   r = 25'sd4;
            5'd21:   r = 25'sd2;
            5'd22:   r = 25'sd1;
            default: r = 25'sd0;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/fpcam_mul.sv =====
module fpcam_mul (
    input  logic                                  aclk,
    input  logic signed [fpcam_pkg::MUL_W-1:0]    a,
    input  logic signed [fpcam_pkg::MUL_W-1:0]    b,
    output logic signed [fpcam_pkg::PROD_W-1:0]   p
);
    import fpcam_pkg::*;

    logic signed [PROD_W-1:0] p_reg;

    always_ff @(posedge aclk) begin
        p_reg <= PROD_W'(a) * PROD_W'(b);
    end

    assign p = p_reg;

endmodule

// ===== sv/fpcam_cordic.sv =====
module fpcam_cordic (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 start,
    input  logic signed [fpcam_pkg::ANG_W-1:0]   angle,
    output logic                                 done,
    output logic signed [fpcam_pkg::TRIG_W-1:0]  cos_q30,
    output logic signed [fpcam_pkg::TRIG_W-1:0]  sin_q30
);
    import fpcam_pkg::*;

    logic signed [TRIG_W-1:0] x_reg, y_reg;
    logic signed [ANG_W-1:0]  z_reg;
    logic [STEP_IW-1:0]       i_reg;
    logic                     run_reg, done_reg, neg_reg;
    logic signed [WRAP_W-1:0] ang_ext;
    logic signed [TRIG_W-1:0] dx, dy;
    logic signed [ANG_W-1:0]  at;

    assign ang_ext = WRAP_W'(angle);
    assign dx = y_reg >>> i_reg;
    assign dy = x_reg >>> i_reg;
    assign at = atan_deg(5'(i_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
            end else if (run_reg && i_reg == STEP_IW'(CORDIC_STEPS - 1)) begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg <= CORDIC_K30;
            y_reg <= '0;
            i_reg <= '0;
            if (ang_ext > DEG_90) begin
                z_reg   <= ANG_W'(ang_ext - DEG_180);
                neg_reg <= 1'b1;
            end else if (ang_ext < -DEG_90) begin
                z_reg   <= ANG_W'(ang_ext + DEG_180);
                neg_reg <= 1'b1;
            end else begin
                z_reg   <= angle;
                neg_reg <= 1'b0;
            end
        end else if (run_reg) begin
            if (!z_reg[ANG_W-1]) begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - at;
            end else begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + at;
            end
            i_reg <= i_reg + 1'b1;
        end
    end

    assign done    = done_reg;
    assign cos_q30 = neg_reg ? -x_reg : x_reg;
    assign sin_q30 = neg_reg ? -y_reg : y_reg;

endmodule

// ===== sv/first_person_camera_update_core.sv =====
// Channel   Dir  Handshake          Payload
// s_        in   s_valid/s_ready    s_cmd s_cursor_x s_cursor_y s_frame_time s_sprint
// m_        out  m_valid/m_ready    m_pos_x/y/z m_front_x/y/z m_heading m_elevation
// cfg_      in   cfg_wr_en          cfg_index cfg_wdata
// One beat at a time through a shared 33x33 multiplier and a 16-step CORDIC.
// A cursor beat runs a 9-step heading wrap plus two CORDIC passes.
// After reset and after a heading or elevation write the front vector is
// rebuilt before s_ready rises.
// The result register holds while m_valid is high and m_ready is low.
module first_person_camera_update_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [3:0]          cfg_index,
    input  logic [31:0]         cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [2:0]          s_cmd,
    input  logic signed [15:0]  s_cursor_x,
    input  logic signed [15:0]  s_cursor_y,
    input  logic [31:0]         s_frame_time,
    input  logic                s_sprint,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [31:0]  m_pos_x,
    output logic signed [31:0]  m_pos_y,
    output logic signed [31:0]  m_pos_z,
    output logic signed [15:0]  m_front_x,
    output logic signed [15:0]  m_front_y,
    output logic signed [15:0]  m_front_z,
    output logic signed [24:0]  m_heading,
    output logic signed [23:0]  m_elevation
);
    import fpcam_pkg::*;

    state_t state_reg, state_next;

    logic [2:0]                cmd_reg;
    logic                      sprint_reg;
    logic [31:0]               now_reg, last_time_reg, step_reg;
    logic signed [16:0]        dx_reg, dy_reg;
    logic signed [15:0]        last_cx_reg, last_cy_reg;
    logic                      first_reg, dirty_reg, job_out_reg;
    logic [POS_WIDTH-1:0]      pos_x_reg, pos_y_reg, pos_z_reg;
    logic signed [ANG_W-1:0]   yaw_reg;
    logic signed [PITCH_W-1:0] pitch_reg;
    logic signed [DIR_W-1:0]   front_x_reg, front_y_reg, front_z_reg;
    logic [15:0]               walk_reg, run_rate_reg, gain_reg;
    logic signed [WRAP_W-1:0]  wrap_reg;
    logic [WK_W-1:0]           wk_reg;
    logic signed [TRIG_W-1:0]  cy_reg, sy_reg, cp_reg, sp_reg;
    logic signed [SIDE_W-1:0]  rx_reg, rz_reg;
    logic                      m_valid_reg;
    logic signed [31:0]        m_pos_x_reg, m_pos_y_reg, m_pos_z_reg;
    logic signed [15:0]        m_front_x_reg, m_front_y_reg, m_front_z_reg;
    logic signed [24:0]        m_heading_reg;
    logic signed [23:0]        m_elevation_reg;

    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic                      cor_start, cor_done;
    logic signed [ANG_W-1:0]   cor_angle;
    logic signed [TRIG_W-1:0]  cor_cos, cor_sin;

    logic                      accept;
    logic signed [15:0]        base_cx, base_cy;
    logic [31:0]               dt;
    logic [15:0]               rate;
    logic signed [PROD_W-1:0]  front_rnd, move_rnd, frame_sum;
    logic [POS_WIDTH-1:0]      delta;
    logic                      neg_move;
    logic signed [WRAP_W-1:0]  pitch_sum, wrap_d, wrap_fix, yaw_cfg;
    logic signed [TRIG_W-1:0]  sin_rnd, cos_rnd, sp_rnd;

    fpcam_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .p    (mul_p)
    );

    fpcam_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cor_start),
        .angle   (cor_angle),
        .done    (cor_done),
        .cos_q30 (cor_cos),
        .sin_q30 (cor_sin)
    );

    assign s_ready = (state_reg == S_IDLE) && !dirty_reg;
    assign accept  = s_valid && s_ready;
    assign base_cx = first_reg ? s_cursor_x : last_cx_reg;
    assign base_cy = first_reg ? s_cursor_y : last_cy_reg;
    assign dt      = now_reg - last_time_reg;
    assign rate    = sprint_reg ? run_rate_reg : walk_reg;

    assign front_rnd = (mul_p + (PROD_W'(1) <<< (FRONT_SH - 1))) >>> FRONT_SH;
    assign move_rnd  = (mul_p + (PROD_W'(1) <<< (DIR_FRAC_BITS - 1))) >>> DIR_FRAC_BITS;
    assign frame_sum = (mul_p + PROD_W'(128)) >>> 8;
    assign delta     = move_rnd[POS_WIDTH-1:0];
    assign neg_move  = (cmd_reg == CMD_BACK) || (cmd_reg == CMD_LEFT);
    assign pitch_sum = WRAP_W'(pitch_reg) + WRAP_W'(mul_p);
    assign wrap_d    = DEG_360 <<< wk_reg;
    assign wrap_fix  = wrap_reg[WRAP_W-1] ? wrap_reg + DEG_360 : wrap_reg;
    assign sin_rnd   = (cor_sin + (TRIG_W'(1) <<< (TRIG_SH - 1))) >>> TRIG_SH;
    assign cos_rnd   = (cor_cos + (TRIG_W'(1) <<< (TRIG_SH - 1))) >>> TRIG_SH;
    assign sp_rnd    = (sp_reg + (TRIG_W'(1) <<< (TRIG_SH - 1))) >>> TRIG_SH;

    always_comb begin
        yaw_cfg = WRAP_W'($signed(cfg_wdata[ANG_W-1:0]));
        if (yaw_cfg >= DEG_180) begin
            yaw_cfg = yaw_cfg - DEG_360;
        end else if (yaw_cfg < -DEG_180) begin
            yaw_cfg = yaw_cfg + DEG_360;
        end
    end

    always_comb begin
        cor_start = (state_reg == S_TRIG_YAW) || (state_reg == S_TRIG_PITCH) ||
                    (state_reg == S_SIDE_TRIG);
        cor_angle = (state_reg == S_TRIG_PITCH) ? ANG_W'(pitch_reg) : yaw_reg;
        mul_a     = MUL_W'({1'b0, step_reg});
        mul_b     = MUL_W'(front_x_reg);
        case (state_reg)
            S_CUR_MULX: begin
                mul_a = MUL_W'(dx_reg);
                mul_b = MUL_W'({1'b0, gain_reg});
            end
            S_CUR_MULY: begin
                mul_a = MUL_W'(dy_reg);
                mul_b = MUL_W'({1'b0, gain_reg});
            end
            S_FRONT_X: begin
                mul_a = cy_reg;
                mul_b = cp_reg;
            end
            S_FRONT_Z: begin
                mul_a = sy_reg;
                mul_b = cp_reg;
            end
            S_FRAME_MUL: begin
                mul_a = MUL_W'({1'b0, rate});
                mul_b = MUL_W'({1'b0, dt});
            end
            S_MOVE_Y: mul_b = MUL_W'(front_y_reg);
            S_MOVE_Z: mul_b = MUL_W'(front_z_reg);
            S_SIDE_X: mul_b = MUL_W'(rx_reg);
            S_SIDE_Z: mul_b = MUL_W'(rz_reg);
            default: ;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (dirty_reg) begin
                    state_next = S_TRIG_YAW;
                end else if (s_valid) begin
                    case (s_cmd)
                        CMD_CURSOR:            state_next = S_CUR_MULX;
                        CMD_FRAME:             state_next = S_FRAME_MUL;
                        CMD_FORWARD, CMD_BACK: state_next = S_MOVE_X;
                        CMD_RIGHT, CMD_LEFT:   state_next = S_SIDE_TRIG;
                        default:               state_next = S_OUT;
                    endcase
                end
            end
            S_CUR_MULX:   state_next = S_CUR_MULY;
            S_CUR_MULY:   state_next = S_CUR_PITCH;
            S_CUR_PITCH:  state_next = S_WRAP;
            S_WRAP:       state_next = (wk_reg == '0) ? S_WRAP_FIX : S_WRAP;
            S_WRAP_FIX:   state_next = S_TRIG_YAW;
            S_TRIG_YAW:   state_next = S_WAIT_YAW;
            S_WAIT_YAW:   state_next = cor_done ? S_TRIG_PITCH : S_WAIT_YAW;
            S_TRIG_PITCH: state_next = S_WAIT_PITCH;
            S_WAIT_PITCH: state_next = cor_done ? S_FRONT_X : S_WAIT_PITCH;
            S_FRONT_X:    state_next = S_FRONT_Z;
            S_FRONT_Z:    state_next = S_FRONT_END;
            S_FRONT_END:  state_next = job_out_reg ? S_OUT : S_IDLE;
            S_FRAME_MUL:  state_next = S_FRAME_END;
            S_FRAME_END:  state_next = S_OUT;
            S_MOVE_X:     state_next = S_MOVE_Y;
            S_MOVE_Y:     state_next = S_MOVE_Z;
            S_MOVE_Z:     state_next = S_MOVE_END;
            S_MOVE_END:   state_next = S_OUT;
            S_SIDE_TRIG:  state_next = S_SIDE_WAIT;
            S_SIDE_WAIT:  state_next = cor_done ? S_SIDE_X : S_SIDE_WAIT;
            S_SIDE_X:     state_next = S_SIDE_Z;
            S_SIDE_Z:     state_next = S_SIDE_END;
            S_SIDE_END:   state_next = S_OUT;
            S_OUT:        state_next = (!m_valid_reg || m_ready) ? S_IDLE : S_OUT;
            default:      state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == S_OUT && (!m_valid_reg || m_ready)) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_OUT && (!m_valid_reg || m_ready)) begin
            m_pos_x_reg     <= 32'($signed(pos_x_reg));
            m_pos_y_reg     <= 32'($signed(pos_y_reg));
            m_pos_z_reg     <= 32'($signed(pos_z_reg));
            m_front_x_reg   <= front_x_reg;
            m_front_y_reg   <= front_y_reg;
            m_front_z_reg   <= front_z_reg;
            m_heading_reg   <= yaw_reg;
            m_elevation_reg <= pitch_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            pos_z_reg     <= POS_WIDTH'(196608);
            yaw_reg       <= ANG_W'(-DEG_90);
            pitch_reg     <= '0;
            step_reg      <= 32'd131072;
            last_time_reg <= '0;
            last_cx_reg   <= '0;
            last_cy_reg   <= '0;
            first_reg     <= 1'b1;
            dirty_reg     <= 1'b1;
            job_out_reg   <= 1'b0;
            walk_reg      <= 16'd1280;
            run_rate_reg  <= 16'd3840;
            gain_reg      <= 16'd6554;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (dirty_reg) begin
                        dirty_reg   <= 1'b0;
                        job_out_reg <= 1'b0;
                    end else if (accept) begin
                        job_out_reg <= 1'b1;
                        if (s_cmd == CMD_CURSOR) begin
                            last_cx_reg <= s_cursor_x;
                            last_cy_reg <= s_cursor_y;
                            first_reg   <= 1'b0;
                        end
                    end
                end
                S_CUR_MULY: begin
                    wrap_reg <= WRAP_W'(yaw_reg) + WRAP_W'(mul_p) + DEG_180;
                    wk_reg   <= WK_W'(WRAP_STEPS - 1);
                end
                S_CUR_PITCH: begin
                    if (pitch_sum > DEG_89) begin
                        pitch_reg <= PITCH_W'(DEG_89);
                    end else if (pitch_sum < -DEG_89) begin
                        pitch_reg <= PITCH_W'(-DEG_89);
                    end else begin
                        pitch_reg <= PITCH_W'(pitch_sum);
                    end
                end
                S_WRAP: begin
                    if (!wrap_reg[WRAP_W-1]) begin
                        if (wrap_reg >= wrap_d) begin
                            wrap_reg <= wrap_reg - wrap_d;
                        end
                    end else if (wrap_reg <= -wrap_d) begin
                        wrap_reg <= wrap_reg + wrap_d;
                    end
                    wk_reg <= wk_reg - 1'b1;
                end
                S_WRAP_FIX: yaw_reg <= ANG_W'(wrap_fix - DEG_180);
                S_FRAME_MUL: last_time_reg <= now_reg;
                S_FRAME_END: begin
                    if (frame_sum[PROD_W-1:32] != '0) begin
                        step_reg <= '1;
                    end else begin
                        step_reg <= frame_sum[31:0];
                    end
                end
                S_MOVE_Y, S_SIDE_Z: pos_x_reg <= neg_move ? pos_x_reg - delta
                                                          : pos_x_reg + delta;
                S_MOVE_Z: pos_y_reg <= neg_move ? pos_y_reg - delta : pos_y_reg + delta;
                S_MOVE_END, S_SIDE_END: pos_z_reg <= neg_move ? pos_z_reg - delta
                                                              : pos_z_reg + delta;
                default: ;
            endcase

            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_START_X: pos_x_reg <= POS_WIDTH'($signed(cfg_wdata));
                    REG_START_Y: pos_y_reg <= POS_WIDTH'($signed(cfg_wdata));
                    REG_START_Z: pos_z_reg <= POS_WIDTH'($signed(cfg_wdata));
                    REG_START_HEAD: begin
                        yaw_reg   <= ANG_W'(yaw_cfg);
                        dirty_reg <= 1'b1;
                    end
                    REG_START_ELEV: begin
                        if ($signed(cfg_wdata[PITCH_W-1:0]) > PITCH_W'(DEG_89)) begin
                            pitch_reg <= PITCH_W'(DEG_89);
                        end else if ($signed(cfg_wdata[PITCH_W-1:0]) <
                                     PITCH_W'(-DEG_89)) begin
                            pitch_reg <= PITCH_W'(-DEG_89);
                        end else begin
                            pitch_reg <= $signed(cfg_wdata[PITCH_W-1:0]);
                        end
                        dirty_reg <= 1'b1;
                    end
                    REG_WALK_RATE:   walk_reg     <= cfg_wdata[15:0];
                    REG_SPRINT_RATE: run_rate_reg <= cfg_wdata[15:0];
                    REG_LOOK_GAIN:   gain_reg     <= cfg_wdata[15:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg    <= s_cmd;
            sprint_reg <= s_sprint;
            now_reg    <= s_frame_time;
            dx_reg     <= 17'(s_cursor_x) - 17'(base_cx);
            dy_reg     <= 17'(base_cy) - 17'(s_cursor_y);
        end
        if (state_reg == S_WAIT_YAW && cor_done) begin
            cy_reg <= cor_cos;
            sy_reg <= cor_sin;
        end
        if (state_reg == S_WAIT_PITCH && cor_done) begin
            cp_reg <= cor_cos;
            sp_reg <= cor_sin;
        end
        if (state_reg == S_SIDE_WAIT && cor_done) begin
            rx_reg <= -SIDE_W'(sin_rnd);
            rz_reg <= SIDE_W'(cos_rnd);
        end
        if (state_reg == S_FRONT_Z) begin
            front_x_reg <= front_rnd[DIR_W-1:0];
        end
        if (state_reg == S_FRONT_END) begin
            front_z_reg <= front_rnd[DIR_W-1:0];
            front_y_reg <= sp_rnd[DIR_W-1:0];
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_pos_x     = m_pos_x_reg;
    assign m_pos_y     = m_pos_y_reg;
    assign m_pos_z     = m_pos_z_reg;
    assign m_front_x   = m_front_x_reg;
    assign m_front_y   = m_front_y_reg;
    assign m_front_z   = m_front_z_reg;
    assign m_heading   = m_heading_reg;
    assign m_elevation = m_elevation_reg;

endmodule

// ===== test/first_person_camera_update_core_test.sv =====
module first_person_camera_update_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import fpcam_pkg::*;

    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int LONG_HOLD   = 400;

    typedef struct {
        logic [2:0]         cmd;
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic [31:0]        t;
        logic               sp;
        bit                 typed;
        logic signed [24:0] hd;
        logic signed [23:0] el;
        logic signed [31:0] pz;
    } event_row_t;

    typedef struct {
        logic [31:0] px, py, pz;
        logic [15:0] fx, fy, fz;
        logic [24:0] hd;
        logic [23:0] el;
    } camera_view_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [3:0]  cfg_index;
    logic [31:0] cfg_wdata;
    logic        s_valid, s_ready;
    logic [2:0]  s_cmd;
    logic signed [15:0] s_cursor_x, s_cursor_y;
    logic [31:0] s_frame_time;
    logic        s_sprint;
    logic        m_valid, m_ready;
    logic signed [31:0] m_pos_x, m_pos_y, m_pos_z;
    logic signed [15:0] m_front_x, m_front_y, m_front_z;
    logic signed [24:0] m_heading;
    logic signed [23:0] m_elevation;

    first_person_camera_update_core dut (.*);

    localparam longint ATAN_Q16 [24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };
    localparam longint D89  = 5832704;
    localparam longint D90  = 5898240;
    localparam longint D180 = 11796480;
    localparam longint D360 = 23592960;
    localparam longint K30  = 652032874;

    logic [31:0]     cam_reg [8];
    longint          cam_pos [3];
    longint          cam_yaw, cam_pitch;
    longint          cam_front [3];
    longint unsigned cam_step;
    logic [31:0]     cam_last_t;
    longint          cam_last_cx, cam_last_cy;
    bit              cam_first;

    camera_view_t view_q [$];
    int     errors = 0;
    int     events_sent = 0;
    int     views_seen = 0;
    int     cycles = 0;
    bit     hold_req = 1'b0;
    int     send_burst = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic longint rnd_sh(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic void cordic_sincos(longint a, output longint c, output longint s);
        bit     flip = 1'b0;
        longint x = K30, y = 0, z, dx, dy;
        if (a > D90) begin
            a -= D180; flip = 1'b1;
        end else if (a < -D90) begin
            a += D180; flip = 1'b1;
        end
        z = a;
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= ATAN_Q16[i];
            end else begin
                x += dx; y -= dy; z += ATAN_Q16[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic longint wrap_heading(longint v);
        longint m = (v + D180) % D360;
        if (m < 0) m += D360;
        return m - D180;
    endfunction

    function automatic longint clamp_elev(longint v);
        if (v > D89) return D89;
        if (v < -D89) return -D89;
        return v;
    endfunction

    function automatic void rebuild_front();
        longint cy, sy, cp, sp;
        cordic_sincos(cam_yaw, cy, sy);
        cordic_sincos(cam_pitch, cp, sp);
        cam_front[0] = rnd_sh(cy * cp, FRONT_SH);
        cam_front[1] = rnd_sh(sp, TRIG_SH);
        cam_front[2] = rnd_sh(sy * cp, FRONT_SH);
    endfunction

    function automatic void load_start(int idx);
        case (idx)
            REG_START_X, REG_START_Y, REG_START_Z:
                cam_pos[idx] = longint'($signed(cam_reg[idx]));
            REG_START_HEAD: begin
                cam_yaw = wrap_heading(longint'($signed(cam_reg[idx][24:0])));
                rebuild_front();
            end
            REG_START_ELEV: begin
                cam_pitch = clamp_elev(longint'($signed(cam_reg[idx][23:0])));
                rebuild_front();
            end
            default: ;
        endcase
    endfunction

    function automatic void camera_reset();
        cam_reg = '{32'd0, 32'd0, 32'd196608, 32'h1A60000, 32'd0, 32'd1280, 32'd3840, 32'd6554};
        for (int i = 0; i < 5; i++) load_start(i);
        cam_step = 131072;
        cam_last_t = '0;
        cam_last_cx = 0;
        cam_last_cy = 0;
        cam_first = 1'b1;
    endfunction

    function automatic void camera_write(logic [3:0] idx, logic [31:0] val);
        if (idx > REG_LOOK_GAIN) return;
        case (idx)
            REG_START_HEAD: cam_reg[idx] = {7'd0, val[24:0]};
            REG_START_ELEV: cam_reg[idx] = {8'd0, val[23:0]};
            REG_WALK_RATE, REG_SPRINT_RATE, REG_LOOK_GAIN: cam_reg[idx] = {16'd0, val[15:0]};
            default: cam_reg[idx] = val;
        endcase
        load_start(idx);
    endfunction

    function automatic camera_view_t camera_event(logic [2:0] cmd, logic signed [15:0] cx,
                                                  logic signed [15:0] cy, logic [31:0] t,
                                                  logic sp);
        camera_view_t    v;
        longint          sgn = 1, st, c, s, rx, rz, gain;
        longint unsigned dt, rate, prod;
        case (cmd)
            CMD_CURSOR: begin
                gain = longint'(cam_reg[REG_LOOK_GAIN]);
                if (cam_first) begin
                    cam_last_cx = cx;
                    cam_last_cy = cy;
                    cam_first = 1'b0;
                end
                cam_yaw = wrap_heading(cam_yaw + (longint'(cx) - cam_last_cx) * gain);
                cam_pitch = clamp_elev(cam_pitch + (cam_last_cy - longint'(cy)) * gain);
                cam_last_cx = cx;
                cam_last_cy = cy;
                rebuild_front();
            end
            CMD_FRAME: begin
                dt = longint'(t - cam_last_t) & 64'hFFFF_FFFF;
                rate = sp ? cam_reg[REG_SPRINT_RATE] : cam_reg[REG_WALK_RATE];
                prod = (rate * dt + 128) >> 8;
                cam_last_t = t;
                cam_step = prod > 64'hFFFF_FFFF ? 64'hFFFF_FFFF : prod;
            end
            CMD_FORWARD, CMD_BACK: begin
                st = longint'(cam_step);
                if (cmd == CMD_BACK) sgn = -1;
                for (int i = 0; i < 3; i++)
                    cam_pos[i] = longint'($signed(32'(cam_pos[i] +
                                 sgn * rnd_sh(st * cam_front[i], DIR_FRAC_BITS))));
            end
            CMD_RIGHT, CMD_LEFT: begin
                st = longint'(cam_step);
                if (cmd == CMD_LEFT) sgn = -1;
                cordic_sincos(cam_yaw, c, s);
                rx = -rnd_sh(s, TRIG_SH);
                rz = rnd_sh(c, TRIG_SH);
                cam_pos[0] = longint'($signed(32'(cam_pos[0] + sgn * rnd_sh(st * rx, DIR_FRAC_BITS))));
                cam_pos[2] = longint'($signed(32'(cam_pos[2] + sgn * rnd_sh(st * rz, DIR_FRAC_BITS))));
            end
            default: ;
        endcase
        v.px = cam_pos[0][31:0];
        v.py = cam_pos[1][31:0];
        v.pz = cam_pos[2][31:0];
        v.fx = cam_front[0][15:0];
        v.fy = cam_front[1][15:0];
        v.fz = cam_front[2][15:0];
        v.hd = cam_yaw[24:0];
        v.el = cam_pitch[23:0];
        return v;
    endfunction

    task automatic send_event(event_row_t r);
        camera_view_t v;
        int           gap;
        s_valid      <= 1'b1;
        s_cmd        <= r.cmd;
        s_cursor_x   <= r.cx;
        s_cursor_y   <= r.cy;
        s_frame_time <= r.t;
        s_sprint     <= r.sp;
        do @(posedge aclk); while (!s_ready);
        v = camera_event(r.cmd, r.cx, r.cy, r.t, r.sp);
        if (r.typed) begin
            v.hd = r.hd;
            v.el = r.el;
            v.pz = r.pz;
        end
        view_q.push_back(v);
        events_sent++;
        if (send_burst > 0) begin
            send_burst--;
            gap = 0;
        end else begin
            gap = $urandom_range(0, 15);
            if ($urandom_range(0, 40) == 0) send_burst = 30;
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (view_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic reg_write(logic [3:0] idx, logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        camera_write(idx, val);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic event_row_t random_event();
        event_row_t r;
        int         k = $urandom_range(0, 99);
        r.typed = 1'b0;
        r.hd = '0; r.el = '0; r.pz = '0;
        r.sp = 1'($urandom_range(0, 1));
        r.cx = 16'($urandom);
        r.cy = 16'($urandom);
        r.t  = $urandom;
        if (k < 28) r.cmd = CMD_CURSOR;
        else if (k < 46) r.cmd = CMD_FRAME;
        else if (k < 95) r.cmd = 3'($urandom_range(CMD_FORWARD, CMD_LEFT));
        else r.cmd = 3'($urandom_range(6, 7));
        if ($urandom_range(0, 9) != 0) begin
            r.cx = 16'(cam_last_cx + $signed($urandom_range(0, 400)) - 200);
            r.cy = 16'(cam_last_cy + $signed($urandom_range(0, 400)) - 200);
            r.t  = cam_last_t + $urandom_range(0, 12000);
        end
        return r;
    endfunction

    task automatic random_events(int n, bit pressure);
        for (int i = 0; i < n; i++) begin
            if (pressure && i == n / 3) hold_req = 1'b1;
            if (pressure && i == 2 * n / 3) begin
                s_valid <= 1'b0;
                while (view_q.size() != 0) @(posedge aclk);
            end
            send_event(random_event());
        end
    endtask

    task automatic check_field(string name, logic [31:0] e, logic [31:0] a);
        if (e !== a) begin
            $error("%s: expected %h, got %h", name, e, a);
            errors++;
        end
    endtask

    initial begin
        camera_view_t e;
        int           stall, burst;
        burst = 0;
        m_ready <= 1'b0;
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end
            if (burst > 0) begin
                burst--;
                stall = 0;
            end else begin
                stall = $urandom_range(0, 15);
                if ($urandom_range(0, 40) == 0) burst = 30;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            views_seen++;
            if (view_q.size() == 0) begin
                $error("result beat with no event outstanding");
                errors++;
            end else begin
                e = view_q.pop_front();
                check_field("pos_x", e.px, m_pos_x);
                check_field("pos_y", e.py, m_pos_y);
                check_field("pos_z", e.pz, m_pos_z);
                check_field("front_x", 32'(e.fx), 32'($unsigned(m_front_x)));
                check_field("front_y", 32'(e.fy), 32'($unsigned(m_front_y)));
                check_field("front_z", 32'(e.fz), 32'($unsigned(m_front_z)));
                check_field("heading", 32'(e.hd), 32'($unsigned(m_heading)));
                check_field("elevation", 32'(e.el), 32'($unsigned(m_elevation)));
            end
        end
    end

    event_row_t directed [20] = '{
        '{CMD_CURSOR, 16'sd100, -16'sd50, 32'd0, 1'b0, 1'b1, -25'sd5898240, 24'sd0, 32'sd196608},
        '{3'd6, 16'sd0, 16'sd0, 32'd0, 1'b0, 1'b1, -25'sd5898240, 24'sd0, 32'sd196608},
        '{CMD_CURSOR, 16'sd32767, -16'sd32768, 32'd0, 1'b0, 1'b0, '0, '0, '0},
        '{CMD_CURSOR, -16'sd32768, 16'sd32767, 32'd0, 1'b0, 1'b0, '0, '0, '0},
        '{CMD_FRAME, 16'sd0, 16'sd0, 32'd65536, 1'b0, 1'b0, '0, '0, '0},
        '{CMD_FORWARD, 16'sd0, 16'sd0, 32'd0, 1'b0, 1'b0, '0, '0, '0},
        '{CMD_BACK, 16'sd0, 16'sd0, 32'd0, 1'b1, 1'b0, '0, '0, '0},
        '{CMD_RIGHT, 16'sd0, 16'sd0, 32'd0, 1'b0, 1'b0, '0, '0, '0},
        '{CMD_LEFT, 16'sd0, 16'sd0, 32'd0, 1'b0, 1'b0, '0, '0, '0},
        '{CMD_FRAME, 16'sd0, 16'sd0, 32'd0, 1'b1, 1'b0, '0, '0, '0},
        '{CMD_FORWARD, 16'sd0, 16'sd0, 32'd0, 1'b0, 1'b0, '0, '0, '0},
        '{CMD_RIGHT, 16'sd0, 16'sd0, 32'd0, 1'b0, 1'b0, '0, '0, '0},
        '{CMD_FRAME, 16'sd0, 16'sd0, 32'hFFFF_FFFF, 1'b0, 1'b0, '0, '0, '0},
        '{CMD_FRAME, 16'sd0, 16'sd0, 32'hFFFF_FFFF, 1'b1, 1'b0, '0, '0, '0},
        '{CMD_FORWARD, 16'sd0, 16'sd0, 32'd0, 1'b0, 1'b0, '0, '0, '0},
        '{3'd7, -16'sd1, -16'sd1, 32'hFFFF_FFFF, 1'b1, 1'b0, '0, '0, '0},
        '{CMD_CURSOR, 16'sd0, 16'sd0, 32'd0, 1'b0, 1'b0, '0, '0, '0},
        '{CMD_FRAME, 16'sd0, 16'sd0, 32'd100, 1'b1, 1'b0, '0, '0, '0},
        '{CMD_LEFT, 16'sd0, 16'sd0, 32'd0, 1'b0, 1'b0, '0, '0, '0},
        '{CMD_BACK, 16'sd0, 16'sd0, 32'd0, 1'b0, 1'b0, '0, '0, '0}
    };

    initial begin
        aresetn      <= 1'b0;
        cfg_wr_en    <= 1'b0;
        cfg_index    <= '0;
        cfg_wdata    <= '0;
        s_valid      <= 1'b0;
        s_cmd        <= CMD_CURSOR;
        s_cursor_x   <= '0;
        s_cursor_y   <= '0;
        s_frame_time <= '0;
        s_sprint     <= 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        camera_reset();
        @(posedge aclk);

        foreach (directed[i]) send_event(directed[i]);
        random_events(200, 1'b0);
        drain();

        for (int i = 0; i < 16; i++) reg_write(4'(i), $urandom);
        random_events(250, 1'b0);
        drain();

        reg_write(REG_START_X, 32'h7FFF_FFFF);
        reg_write(REG_START_Y, 32'h8000_0000);
        reg_write(REG_START_Z, 32'h0);
        reg_write(REG_START_HEAD, 32'h0FF_FFFF);
        reg_write(REG_START_ELEV, 32'h7F_FFFF);
        reg_write(REG_WALK_RATE, 32'hFFFF);
        reg_write(REG_SPRINT_RATE, 32'hFFFF);
        reg_write(REG_LOOK_GAIN, 32'hFFFF);
        random_events(200, 1'b0);
        drain();

        reg_write(REG_START_HEAD, 32'h100_0000);
        reg_write(REG_START_ELEV, 32'h80_0000);
        reg_write(REG_WALK_RATE, 32'h0);
        reg_write(REG_SPRINT_RATE, 32'h0);
        reg_write(REG_LOOK_GAIN, 32'h0);
        random_events(180, 1'b0);
        drain();

        reg_write(REG_START_X, $urandom);
        reg_write(REG_START_HEAD, $urandom_range(0, 23592959) - 11796480);
        reg_write(REG_START_ELEV, $urandom_range(0, 11665408) - 5832704);
        reg_write(REG_WALK_RATE, $urandom_range(0, 4096));
        reg_write(REG_SPRINT_RATE, $urandom_range(0, 8192));
        reg_write(REG_LOOK_GAIN, $urandom_range(0, 20000));
        random_events(300, 1'b1);
        drain();
        repeat (100) @(posedge aclk);

        if (view_q.size() != 0) begin
            $error("%0d expected results never arrived", view_q.size());
            errors++;
        end
        $display("Checked %0d camera events (%0d results) over five register settings,",
                 events_sent, views_seen);
        $display("covering all commands, time reversal, step saturation and long back-pressure.");
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
